FILE: rtl/core/mfs_pkg.sv
package mfs_pkg;
	localparam int STACK_DEPTH = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic               func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] popped_value;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [3:0] {
		CMD_IDLE, CMD_LOAD, CMD_PSCAN, CMD_PUSH, CMD_MSCAN,
		CMD_WRD, CMD_WCHK, CMD_SHRD, CMD_SHWR, CMD_POPDONE
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_last;
		logic slot_hit;
		logic walk_hit;
		logic shift_last;
	} sts_t;
endpackage

FILE: rtl/core/mfs_dp.sv
module mfs_dp import mfs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  req_t  req,
	output sts_t  sts,
	output logic signed [31:0] pop_val
);
	logic [VALUE_WIDTH-1:0] stk_mem [STACK_DEPTH];
	logic [VALUE_WIDTH-1:0] dval_q [STACK_DEPTH];
	logic [CNT_W-1:0] dcnt_q [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] dvld_q;
	logic [CNT_W-1:0] fill_q;
	logic [VALUE_WIDTH-1:0] v_q, rd_q, pv_q;
	logic [IDX_W-1:0] scan_q, slot_q, free_q, pos_q;
	logic slot_ok_q, free_ok_q;
	logic [CNT_W-1:0] top_q, slot_cnt_q;
	logic [IDX_W-1:0] ra, idx_s1;
	logic [VALUE_WIDTH-1:0] sv_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic hit, walk_hit;

	// Slot table read address; LOAD and WRD restart the scan at slot 0.
	assign ra = (cmd == CMD_LOAD || cmd == CMD_WRD) ? '0 : scan_q;

	// Value match against the slot read out in the previous cycle.
	assign hit = dvld_q[idx_s1] && sv_s1 == rd_q;
	assign walk_hit = hit && cnt_s1 == top_q;

	always_comb begin
		sts.full = fill_q == CNT_W'(STACK_DEPTH);
		sts.empty = fill_q == '0;
		sts.scan_last = idx_s1 == IDX_W'(STACK_DEPTH - 1);
		sts.slot_hit = hit;
		sts.walk_hit = walk_hit;
		sts.shift_last = CNT_W'(pos_q) + CNT_W'(1) >= fill_q;
	end
	assign pop_val = 32'(pv_q);

	always_ff @(posedge clk) begin
		sv_s1 <= dval_q[ra];
		cnt_s1 <= dcnt_q[ra];
		if (cmd == CMD_PUSH)
			stk_mem[fill_q[IDX_W-1:0]] <= v_q;
		else if (cmd == CMD_SHWR)
			stk_mem[pos_q] <= rd_q;
		if (cmd == CMD_WRD)
			rd_q <= stk_mem[pos_q];
		else if (cmd == CMD_SHRD)
			rd_q <= stk_mem[IDX_W'(pos_q + 1'b1)];
		else if (cmd == CMD_POPDONE)
			rd_q <= rd_q;
		if (cmd == CMD_PUSH) begin
			if (slot_ok_q) dcnt_q[slot_q] <= slot_cnt_q + 1'b1;
			else begin
				dcnt_q[free_q] <= CNT_W'(1);
				dval_q[free_q] <= v_q;
			end
		end else if (cmd == CMD_WCHK && walk_hit)
			dcnt_q[idx_s1] <= cnt_s1 - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0; dvld_q <= '0; scan_q <= '0; slot_q <= '0; free_q <= '0;
			pos_q <= '0; slot_ok_q <= 1'b0; free_ok_q <= 1'b0; top_q <= '0;
			v_q <= '0; idx_s1 <= '0; slot_cnt_q <= '0; pv_q <= '0;
		end else begin
			idx_s1 <= ra;
			unique case (cmd)
				CMD_LOAD: begin
					v_q <= VALUE_WIDTH'(req.value);
					scan_q <= IDX_W'(1); slot_ok_q <= 1'b0; free_ok_q <= 1'b0; top_q <= '0;
					pos_q <= IDX_W'(fill_q - 1'b1);
				end
				CMD_PSCAN: begin
					if (dvld_q[idx_s1]) begin
						if (!slot_ok_q && sv_s1 == v_q) begin
							slot_q <= idx_s1; slot_ok_q <= 1'b1; slot_cnt_q <= cnt_s1;
						end
					end else if (!free_ok_q) begin
						free_q <= idx_s1; free_ok_q <= 1'b1;
					end
					scan_q <= IDX_W'(scan_q + 1'b1);
				end
				CMD_PUSH: begin
					if (!slot_ok_q) dvld_q[free_q] <= 1'b1;
					fill_q <= fill_q + 1'b1;
				end
				CMD_MSCAN: begin
					if (dvld_q[idx_s1] && cnt_s1 > top_q) top_q <= cnt_s1;
					scan_q <= IDX_W'(scan_q + 1'b1);
				end
				CMD_WRD: scan_q <= IDX_W'(1);
				CMD_WCHK: begin
					// Take the entry on a match at the top count; on any other match
					// or at the end of the table, step down to the next entry.
					if (walk_hit) begin
						if (cnt_s1 == CNT_W'(1)) dvld_q[idx_s1] <= 1'b0;
						pv_q <= rd_q;
					end else if (hit || idx_s1 == IDX_W'(STACK_DEPTH - 1)) begin
						pos_q <= IDX_W'(pos_q - 1'b1);
					end else scan_q <= IDX_W'(scan_q + 1'b1);
				end
				CMD_SHRD: ;
				CMD_SHWR: pos_q <= IDX_W'(pos_q + 1'b1);
				CMD_POPDONE: fill_q <= fill_q - 1'b1;
				default: ;
			endcase
		end
	end
endmodule

FILE: rtl/core/mfs_ctl.sv
module mfs_ctl import mfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_func,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd,
	output logic out_load,
	output logic [1:0] out_status,
	output logic out_zero
);
	typedef enum logic [3:0] {
		S_IDLE, S_PSCAN, S_PUSH, S_MSCAN, S_WRD, S_WCHK,
		S_SHCHK, S_SHRD, S_SHWR, S_DONE
	} state_t;
	state_t state_q;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		cmd = CMD_IDLE;
		unique case (state_q)
			S_IDLE:  cmd = (in_valid) ? CMD_LOAD : CMD_IDLE;
			S_PSCAN: cmd = CMD_PSCAN;
			S_PUSH:  cmd = CMD_PUSH;
			S_MSCAN: cmd = CMD_MSCAN;
			S_WRD:   cmd = CMD_WRD;
			S_WCHK:  cmd = CMD_WCHK;
			S_SHRD:  cmd = CMD_SHRD;
			S_SHWR:  cmd = CMD_SHWR;
			S_DONE:  cmd = CMD_POPDONE;
			default: cmd = CMD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_load <= 1'b0; out_status <= ST_OK; out_zero <= 1'b1;
		end else begin
			out_load <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					if (!in_func && sts.full) begin
						out_load <= 1'b1; out_status <= ST_FULL; out_zero <= 1'b1;
					end else if (in_func && sts.empty) begin
						out_load <= 1'b1; out_status <= ST_EMPTY; out_zero <= 1'b1;
					end else state_q <= in_func ? S_MSCAN : S_PSCAN;
				end
				S_PSCAN: if (sts.scan_last) state_q <= S_PUSH;
				S_PUSH: begin
					out_load <= 1'b1; out_status <= ST_OK; out_zero <= 1'b1;
					state_q <= S_IDLE;
				end
				S_MSCAN: if (sts.scan_last) state_q <= S_WRD;
				S_WRD: state_q <= S_WCHK;
				S_WCHK: begin
					if (sts.walk_hit) state_q <= S_SHCHK;
					else if (sts.slot_hit || sts.scan_last) state_q <= S_WRD;
				end
				S_SHCHK: state_q <= sts.shift_last ? S_DONE : S_SHRD;
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: state_q <= S_SHCHK;
				S_DONE: begin
					out_load <= 1'b1; out_status <= ST_OK; out_zero <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/core/max_frequency_stack.sv
// Channel | Direction | Handshake      | Beat
// in      | input     | in_valid/stall | req_t  (func, value)
// out     | output    | out_valid/stall| rsp_t  (popped_value, status)
// Work per in beat: a push makes one slot table pass; an empty pop or full push is
// answered without a scan; a pop makes one slot table pass for the top count, then walks
// stack entries down from the top, scanning the slot table for each, then shifts
// the entries above the taken one down. The slot table is scanned one slot per cycle.
// Reset clears fill and slot valid bits; counts and values are read in valid slots only.
// Stall in while a beat is worked, loading or waiting on out.
module max_frequency_stack import mfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);
	cmd_t cmd;
	sts_t sts;
	logic ctl_stall, load, zero;
	logic [1:0] st;
	logic signed [31:0] pv;
	logic in_ok;

	// Hold new work while a result beat is loading or still waiting.
	assign in_stall = ctl_stall || out_valid || load;
	assign in_ok = in_valid && !out_valid && !load;

	mfs_ctl u_ctl (.clk, .arst_n, .in_valid(in_ok), .in_func(in_data.func),
		.in_stall(ctl_stall), .sts, .cmd, .out_load(load), .out_status(st),
		.out_zero(zero));
	mfs_dp u_dp (.clk, .arst_n, .cmd, .req(in_data), .sts, .pop_val(pv));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				out_data.status <= st;
				out_data.popped_value <= zero ? 32'sd0 : pv;
			end else if (out_valid && !out_stall) out_valid <= 1'b0;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped");
	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !out_valid) else $error("result overwritten");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3) else $error("bad status");
endmodule

FILE: verif/mfs_tb_pkg.sv
package mfs_tb_pkg;
	localparam logic FN_PUSH = 1'b0;
	localparam logic FN_POP  = 1'b1;
endpackage

FILE: verif/mfs_checker.sv
module mfs_checker import mfs_pkg::*, mfs_tb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  req_t in_data,
	input  logic out_valid,
	input  logic out_stall,
	input  rsp_t out_data,
	output int   errors,
	output int   pending,
	output int   n_empty,
	output int   n_full,
	output int   n_pops
);
	logic signed [31:0] held[STACK_DEPTH];
	int held_fill;
	rsp_t expected_rsp[$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int copies(input logic signed [31:0] v);
		int n;
		n = 0;
		for (int i = 0; i < held_fill; i++)
			if (held[i] == v) n++;
		return n;
	endfunction

	// remove the most frequent value, nearest the top on a tie
	function automatic logic signed [31:0] pop_most_frequent();
		int top;
		logic signed [31:0] v;
		top = 0;
		v = '0;
		for (int i = 0; i < held_fill; i++)
			if (copies(held[i]) > top) top = copies(held[i]);
		for (int pos = held_fill - 1; pos >= 0; pos--) begin
			if (copies(held[pos]) == top) begin
				v = held[pos];
				for (int i = pos; i + 1 < held_fill; i++) held[i] = held[i + 1];
				held_fill--;
				return v;
			end
		end
		return v;
	endfunction

	function automatic rsp_t predict(input req_t r);
		rsp_t o;
		o.popped_value = '0;
		o.status = ST_OK;
		if (r.func == FN_PUSH) begin
			if (held_fill >= STACK_DEPTH) o.status = ST_FULL;
			else begin
				held[held_fill] = r.value;
				held_fill++;
			end
		end else if (held_fill == 0) o.status = ST_EMPTY;
		else o.popped_value = pop_most_frequent();
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			held_fill = 0;
			expected_rsp.delete();
			errors = 0;
			n_empty = 0;
			n_full = 0;
			n_pops = 0;
			pending = 0;
		end else begin
			if (in_valid && !in_stall) begin
				want = predict(in_data);
				if (want.status == ST_EMPTY) n_empty++;
				if (want.status == ST_FULL) n_full++;
				if (in_data.func == FN_POP && want.status == ST_OK) n_pops++;
				expected_rsp = {expected_rsp, want};
			end
			if (out_valid && !out_stall) begin
				if (expected_rsp.size() == 0)
					report("unexpected beat", out_data.popped_value, '0);
				else begin
					want = expected_rsp.pop_front();
					if (out_data.popped_value !== want.popped_value)
						report("popped_value", out_data.popped_value, want.popped_value);
					if (out_data.status !== want.status)
						report("status", 32'(out_data.status), 32'(want.status));
				end
			end
			pending = expected_rsp.size();
		end
	end
endmodule

FILE: verif/tb.sv
module tb;
	import mfs_pkg::*;
	import mfs_tb_pkg::*;

	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int RANDOM_ITEMS = 900;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;

	int errors, pending, n_empty, n_full, n_pops;
	int cycles;
	int sent;
	bit calm;       // no random idling on either side while set (the long hold-off still applies)
	bit hold_go;    // ask the receiver for one long hold-off
	logic [31:0] pool[4];

	max_frequency_stack dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	mfs_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.errors(errors), .pending(pending),
		.n_empty(n_empty), .n_full(n_full), .n_pops(n_pops)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Watchdog: a hung block ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (calm || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	// Receiver: random stall, plus one long hold-off counted here.
	always @(negedge clk) begin
		int stall_left;
		int hold_left;
		logic nxt;
		if (hold_go) begin
			hold_go = 0;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			nxt = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			nxt = 1'b1;
		end else begin
			stall_left = gap_len();
			nxt = (stall_left > 0);
		end
		out_stall <= nxt;
	end

	// Offer one beat; valid stays high across back-to-back beats.
	task automatic send(input logic fn, input logic [31:0] v);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.func <= fn;
		in_data.value <= v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int n, push_pct;
		logic [31:0] v;
		cycles = 0;
		sent = 0;
		calm = 0;
		hold_go = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty pop, value extremes, a tie resolved toward the top.
		send(FN_POP, 32'hFFFF_FFFF);
		send(FN_PUSH, 32'h7FFF_FFFF);
		send(FN_PUSH, 32'h8000_0000);
		send(FN_PUSH, 32'h0000_0000);
		send(FN_PUSH, 32'hFFFF_FFFF);
		send(FN_PUSH, 32'h5555_5555);
		send(FN_PUSH, 32'hAAAA_AAAA);
		send(FN_PUSH, 32'hFFFF_FFFF);
		send(FN_PUSH, 32'h0000_0000);
		repeat (9) send(FN_POP, $urandom);
		send(FN_POP, 32'h0);

		// Fill to the top, then push twice more to hit the full case.
		calm = 1;
		for (int i = 0; i < STACK_DEPTH + 2; i++) send(FN_PUSH, $urandom_range(3));
		calm = 0;
		drain();

		// Random phases: few distinct values so frequencies build up.
		n = 0;
		while (sent < RANDOM_ITEMS) begin
			for (int i = 0; i < 4; i++) pool[i] = $urandom;
			if ($urandom_range(3) == 0) pool[0] = 32'h8000_0000;
			case ($urandom_range(2))
				0: push_pct = 85;
				1: push_pct = 50;
				default: push_pct = 25;
			endcase
			calm = ($urandom_range(4) == 0);
			if (n == 3) hold_go = 1;
			repeat ($urandom_range(20, 80)) begin
				if ($urandom_range(9) == 0) v = $urandom;
				else v = pool[$urandom_range(3)];
				send(($urandom_range(99) < push_pct) ? FN_PUSH : FN_POP, v);
			end
			// Every few phases, wait for the block to drain before moving on.
			if (n % 4 == 1) drain();
			n++;
		end

		drain();
		repeat (200) @(negedge clk);
		$display("covered %0d beats: %0d pops returned a value, %0d empty pops, %0d full pushes",
			sent, n_pops, n_empty, n_full);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
